// ----- rtl/tilt_compensated_compass_heading_unit_defines.svh -----
// Assertion macros shared by the checker files.
`ifndef TILT_COMPENSATED_COMPASS_HEADING_UNIT_DEFINES_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_UNIT_DEFINES_SVH

// Consequence must hold in the cycle after the antecedent.
`define TCCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequence must hold in the same cycle as the antecedent.
`define TCCH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tcch_pkg.sv -----
// ----------------------------------------------------------------------------
// tcch_pkg
// Shared constants, command codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcch_pkg;

  // CORDIC iteration count (8 to 24)
  localparam int CORDIC_ITERATIONS = 16;
  // step counter: covers 24 CORDIC steps, 16 root steps, 9 multiply steps
  localparam int CNT_W = 5;
  // CORDIC datapath width
  localparam int DW = 54;

  localparam logic [31:0] GAIN_Q30 = 32'h26DD3B6A;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_LOAD   = 2'd3
  } cmd_t;

  localparam logic [1:0] CFG_TILT_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_DECLINATION   = 2'd1;
  localparam logic [1:0] CFG_STALE_EPSILON = 2'd2;

  typedef logic signed [DW-1:0] dw_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_entry(input logic [CNT_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/tilt_compensated_compass_heading_unit.sv -----
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_unit
// Hard-iron corrected, tilt-compensated compass heading on one shared CORDIC.
// A tilt-compensated sample runs six CORDIC passes, a 16-step square root
//   and nine multiplies.
// Takes one item at a time: no new item until the result enters the output
//   register.
// Reset (synchronous, rst_n low): control and config registers to defaults, calibration cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_compensated_compass_heading_unit (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  // input items
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_command,
  input  logic signed [15:0]  in_mag_x,
  input  logic signed [15:0]  in_mag_y,
  input  logic signed [15:0]  in_mag_z,
  input  logic signed [15:0]  in_accel_x,
  input  logic signed [15:0]  in_accel_y,
  input  logic signed [15:0]  in_accel_z,
  input  logic                in_accel_valid,
  input  logic [31:0]         in_time_ms,
  // result items
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_heading,
  output logic signed [15:0]  out_yaw,
  output logic signed [16:0]  out_corrected_x,
  output logic signed [16:0]  out_corrected_y,
  output logic signed [16:0]  out_corrected_z,
  output logic [31:0]         out_stale_time,
  output logic                out_heading_valid,
  output logic                out_calibration_done,
  output logic                out_calibration_active
);

  localparam int CW = tcch_pkg::CNT_W;
  localparam logic [CW-1:0] LAST_ITER = CW'(tcch_pkg::CORDIC_ITERATIONS - 1);
  localparam logic [CW-1:0] LAST_ROOT = CW'(15);

  // multiply steps
  localparam logic [CW-1:0] MI_AYY  = CW'(0);
  localparam logic [CW-1:0] MI_AZZ  = CW'(1);
  localparam logic [CW-1:0] MI_SRSP = CW'(2);
  localparam logic [CW-1:0] MI_SRCP = CW'(3);
  localparam logic [CW-1:0] MI_XCP  = CW'(4);
  localparam logic [CW-1:0] MI_ZSP  = CW'(5);
  localparam logic [CW-1:0] MI_XS   = CW'(6);
  localparam logic [CW-1:0] MI_YCR  = CW'(7);
  localparam logic [CW-1:0] MI_ZC   = CW'(8);

  typedef enum logic [2:0] {
    ST_IDLE, ST_VEC, ST_ROT, ST_FIN, ST_MUL, ST_MACC, ST_SQRT, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    JB_YAW, JB_ROLL, JB_PITCH, JB_HEAD, JB_SCR, JB_SCP
  } job_t;

  // control and configuration
  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic tilt_en_r, tilt_en_nxt;
  logic signed [15:0] decl_r, decl_nxt;
  logic [15:0] eps_r, eps_nxt;

  // architectural state
  logic signed [15:0] min_r [3], min_nxt [3];
  logic signed [15:0] max_r [3], max_nxt [3];
  logic signed [15:0] off_r [3], off_nxt [3];
  logic signed [16:0] prev_r [3], prev_nxt [3];
  logic [31:0] prev_time_r, prev_time_nxt;
  logic [31:0] stale_r, stale_nxt;
  logic track_r, track_nxt;
  logic have_r, have_nxt;
  logic cal_r, cal_nxt;

  // item working registers
  logic signed [16:0] corr_r [3], corr_nxt [3];
  logic signed [15:0] ax_r, ax_nxt, ay_r, ay_nxt, az_r, az_nxt;
  logic tilt_on_r, tilt_on_nxt;
  logic hv_r, hv_nxt;
  logic [15:0] yaw_r, yaw_nxt, head_r, head_nxt;
  logic [15:0] roll_r, roll_nxt, pitch_r, pitch_nxt;
  logic [15:0] ryz_r, ryz_nxt;
  logic signed [31:0] cr_r, cr_nxt, sr_r, sr_nxt, cp_r, cp_nxt, sp_r, sp_nxt;
  logic signed [31:0] srsp_r, srsp_nxt, srcp_r, srcp_nxt;

  // shared units
  tcch_pkg::dw_t cx_r, cx_nxt, cy_r, cy_nxt, acc_r, acc_nxt, xh_r, xh_nxt;
  logic [31:0] cz_r, cz_nxt;
  logic zero_r, zero_nxt, flip_r, flip_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [31:0] sq_v_r, sq_v_nxt, sq_res_r, sq_res_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic [15:0] out_heading_r, out_heading_nxt;
  logic signed [15:0] out_yaw_r, out_yaw_nxt;
  logic signed [16:0] out_cx_r, out_cx_nxt, out_cy_r, out_cy_nxt, out_cz_r, out_cz_nxt;
  logic [31:0] out_stale_r, out_stale_nxt;
  logic out_hv_r, out_hv_nxt, out_cal_r, out_cal_nxt, out_act_r, out_act_nxt;

  logic signed [15:0] mag_in [3];
  assign mag_in[0] = in_mag_x;
  assign mag_in[1] = in_mag_y;
  assign mag_in[2] = in_mag_z;

  assign in_ready               = (state_r == ST_IDLE);
  assign out_valid              = out_valid_r;
  assign out_heading            = out_heading_r;
  assign out_yaw                = out_yaw_r;
  assign out_corrected_x        = out_cx_r;
  assign out_corrected_y        = out_cy_r;
  assign out_corrected_z        = out_cz_r;
  assign out_stale_time         = out_stale_r;
  assign out_heading_valid      = out_hv_r;
  assign out_calibration_done   = out_cal_r;
  assign out_calibration_active = out_act_r;

  // CORDIC step unit
  tcch_pkg::dw_t sh_x, sh_y;
  logic [31:0] at;
  logic up;
  assign sh_x = cx_r >>> cnt_r;
  assign sh_y = cy_r >>> cnt_r;
  assign at   = tcch_pkg::atan_entry(cnt_r);
  assign up   = (state_r == ST_VEC) ? (!cy_r[tcch_pkg::DW-1] && (cy_r != '0)) : cz_r[31];

  // shared multiplier operands
  logic signed [31:0] op_a, op_b;
  always_comb begin
    case (cnt_r)
      MI_AYY:  begin op_a = 32'(ay_r);      op_b = 32'(ay_r);  end
      MI_AZZ:  begin op_a = 32'(az_r);      op_b = 32'(az_r);  end
      MI_SRSP: begin op_a = sr_r;           op_b = sp_r;       end
      MI_SRCP: begin op_a = sr_r;           op_b = cp_r;       end
      MI_XCP:  begin op_a = 32'(corr_r[0]); op_b = cp_r;       end
      MI_ZSP:  begin op_a = 32'(corr_r[2]); op_b = sp_r;       end
      MI_XS:   begin op_a = 32'(corr_r[0]); op_b = srsp_r;     end
      MI_YCR:  begin op_a = 32'(corr_r[1]); op_b = cr_r;       end
      MI_ZC:   begin op_a = 32'(corr_r[2]); op_b = srcp_r;     end
      default: begin op_a = '0;             op_b = '0;         end
    endcase
  end

  // sequencer and datapath
  always_comb begin
    logic signed [16:0] c [3];
    logic signed [17:0] diff;
    logic [17:0] mag_d;
    logic still;
    logic [31:0] dt;
    logic [32:0] ssum;
    logic signed [16:0] mid;
    logic ld_vec, ld_rot;
    tcch_pkg::dw_t vx, vy, fx, fy, psum;
    logic [15:0] ra, a16;
    logic [31:0] ra32, rbit;
    logic [32:0] rt;
    logic [31:0] r_res, r_v;
    job_t vjob, rjob;

    state_nxt = state_r;  job_nxt = job_r;  cnt_nxt = cnt_r;
    tilt_en_nxt = tilt_en_r;  decl_nxt = decl_r;  eps_nxt = eps_r;
    for (int i = 0; i < 3; i++) begin
      min_nxt[i] = min_r[i];  max_nxt[i] = max_r[i];  off_nxt[i] = off_r[i];
      prev_nxt[i] = prev_r[i];  corr_nxt[i] = corr_r[i];
    end
    prev_time_nxt = prev_time_r;  stale_nxt = stale_r;
    track_nxt = track_r;  have_nxt = have_r;  cal_nxt = cal_r;
    ax_nxt = ax_r;  ay_nxt = ay_r;  az_nxt = az_r;
    tilt_on_nxt = tilt_on_r;  hv_nxt = hv_r;
    yaw_nxt = yaw_r;  head_nxt = head_r;  roll_nxt = roll_r;  pitch_nxt = pitch_r;
    ryz_nxt = ryz_r;
    cr_nxt = cr_r;  sr_nxt = sr_r;  cp_nxt = cp_r;  sp_nxt = sp_r;
    srsp_nxt = srsp_r;  srcp_nxt = srcp_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  cz_nxt = cz_r;  acc_nxt = acc_r;  xh_nxt = xh_r;
    zero_nxt = zero_r;  flip_nxt = flip_r;  prod_nxt = prod_r;
    sq_v_nxt = sq_v_r;  sq_res_nxt = sq_res_r;
    out_valid_nxt = out_valid_r;
    out_heading_nxt = out_heading_r;  out_yaw_nxt = out_yaw_r;
    out_cx_nxt = out_cx_r;  out_cy_nxt = out_cy_r;  out_cz_nxt = out_cz_r;
    out_stale_nxt = out_stale_r;
    out_hv_nxt = out_hv_r;  out_cal_nxt = out_cal_r;  out_act_nxt = out_act_r;

    ld_vec = 1'b0;  ld_rot = 1'b0;
    vx = '0;  vy = '0;  ra = '0;  vjob = JB_YAW;  rjob = JB_SCR;
    still = 1'b1;  diff = '0;  mag_d = '0;  dt = '0;  ssum = '0;  mid = '0;
    fx = '0;  fy = '0;  psum = '0;  a16 = '0;  ra32 = '0;
    rbit = '0;  rt = '0;  r_res = '0;  r_v = '0;
    for (int i = 0; i < 3; i++) c[i] = '0;

    // configuration writes
    if (cfg_wr_en) begin
      unique case (cfg_index)
        tcch_pkg::CFG_TILT_ENABLE:   tilt_en_nxt = cfg_data[0];
        tcch_pkg::CFG_DECLINATION:   decl_nxt = cfg_data;
        tcch_pkg::CFG_STALE_EPSILON: eps_nxt = cfg_data;
        default: ;
      endcase
    end

    // drop the result once taken
    if (out_ready) out_valid_nxt = 1'b0;

    // CORDIC rounding of the finished angle
    a16 = zero_r ? 16'h0 : 16'((cz_r + 32'h8000) >> 16);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          hv_nxt = 1'b0;  yaw_nxt = '0;  head_nxt = '0;
          ax_nxt = in_accel_x;  ay_nxt = in_accel_y;  az_nxt = in_accel_z;
          tilt_on_nxt = tilt_en_r && in_accel_valid;
          state_nxt = ST_DONE;
          unique case (tcch_pkg::cmd_t'(in_command))
            tcch_pkg::CMD_SAMPLE: begin
              // track extremes
              if (track_r) begin
                for (int i = 0; i < 3; i++) begin
                  if (!have_r || mag_in[i] < min_r[i]) min_nxt[i] = mag_in[i];
                  if (!have_r || mag_in[i] > max_r[i]) max_nxt[i] = mag_in[i];
                end
                have_nxt = 1'b1;
              end
              // correct and test for motion
              for (int i = 0; i < 3; i++) begin
                c[i] = 17'(mag_in[i]) - 17'(off_r[i]);
                corr_nxt[i] = c[i];
                diff = 18'(c[i]) - 18'(prev_r[i]);
                mag_d = diff[17] ? 18'(-diff) : 18'(diff);
                if (!(mag_d < {2'b00, eps_r})) still = 1'b0;
                prev_nxt[i] = c[i];
              end
              dt = in_time_ms - prev_time_r;
              ssum = {1'b0, stale_r} + {1'b0, dt};
              if (still) begin
                if (prev_time_r != '0) stale_nxt = ssum[32] ? 32'hFFFFFFFF : ssum[31:0];
              end else begin
                stale_nxt = '0;
              end
              prev_time_nxt = in_time_ms;
              hv_nxt = 1'b1;
              ld_vec = 1'b1;
              vx = tcch_pkg::dw_t'(c[0]) <<< 20;
              vy = tcch_pkg::dw_t'(c[1]) <<< 20;
              vjob = JB_YAW;
            end
            tcch_pkg::CMD_START: begin
              track_nxt = 1'b1;  have_nxt = 1'b0;  cal_nxt = 1'b0;
              for (int i = 0; i < 3; i++) corr_nxt[i] = '0;
            end
            tcch_pkg::CMD_FINISH: begin
              for (int i = 0; i < 3; i++) begin
                mid = 17'(max_r[i]) + 17'(min_r[i]);
                corr_nxt[i] = 17'(off_r[i]);
                if (track_r && have_r) begin
                  off_nxt[i] = mid[16:1];
                  corr_nxt[i] = 17'($signed(mid[16:1]));
                end
              end
              if (track_r) begin
                track_nxt = 1'b0;
                cal_nxt = have_r;
              end
            end
            tcch_pkg::CMD_LOAD: begin
              for (int i = 0; i < 3; i++) begin
                off_nxt[i] = mag_in[i];
                corr_nxt[i] = 17'(mag_in[i]);
              end
              cal_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end

      ST_VEC, ST_ROT: begin
        // one CORDIC iteration
        if (up) begin
          cx_nxt = cx_r + sh_y;  cy_nxt = cy_r - sh_x;  cz_nxt = cz_r + at;
        end else begin
          cx_nxt = cx_r - sh_y;  cy_nxt = cy_r + sh_x;  cz_nxt = cz_r - at;
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST_ITER) state_nxt = ST_FIN;
      end

      ST_FIN: begin
        fx = flip_r ? -cx_r : cx_r;
        fy = flip_r ? -cy_r : cy_r;
        unique case (job_r)
          JB_YAW: begin
            yaw_nxt = a16;
            if (tilt_on_r) begin
              cnt_nxt = MI_AYY;
              state_nxt = ST_MUL;
            end else begin
              head_nxt = a16 + decl_r;
              state_nxt = ST_DONE;
            end
          end
          JB_ROLL: begin
            roll_nxt = a16;
            ld_vec = 1'b1;
            vx = tcch_pkg::dw_t'({1'b0, ryz_r}) <<< 20;
            vy = -(tcch_pkg::dw_t'(ax_r) <<< 20);
            vjob = JB_PITCH;
          end
          JB_PITCH: begin
            pitch_nxt = a16;
            ld_rot = 1'b1;  ra = roll_r;  rjob = JB_SCR;
          end
          JB_SCR: begin
            cr_nxt = fx[31:0];  sr_nxt = fy[31:0];
            ld_rot = 1'b1;  ra = pitch_r;  rjob = JB_SCP;
          end
          JB_SCP: begin
            cp_nxt = fx[31:0];  sp_nxt = fy[31:0];
            cnt_nxt = MI_SRSP;
            state_nxt = ST_MUL;
          end
          JB_HEAD: begin
            head_nxt = a16 + decl_r;
            state_nxt = ST_DONE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      ST_MUL: begin
        prod_nxt = op_a * op_b;
        state_nxt = ST_MACC;
      end

      ST_MACC: begin
        psum = acc_r + prod_r[tcch_pkg::DW-1:0];
        state_nxt = ST_MUL;
        cnt_nxt = cnt_r + CW'(1);
        case (cnt_r)
          MI_AYY:  acc_nxt = prod_r[tcch_pkg::DW-1:0];
          MI_AZZ: begin
            sq_v_nxt = psum[31:0];
            sq_res_nxt = '0;
            cnt_nxt = '0;
            state_nxt = ST_SQRT;
          end
          MI_SRSP: srsp_nxt = prod_r[61:30];
          MI_SRCP: srcp_nxt = prod_r[61:30];
          MI_XCP:  acc_nxt = prod_r[tcch_pkg::DW-1:0];
          MI_ZSP:  xh_nxt = psum;
          MI_XS:   acc_nxt = prod_r[tcch_pkg::DW-1:0];
          MI_YCR:  acc_nxt = psum;
          MI_ZC: begin
            ld_vec = 1'b1;
            vx = xh_r;
            vy = acc_r - prod_r[tcch_pkg::DW-1:0];
            vjob = JB_HEAD;
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      ST_SQRT: begin
        // one bit pair of the integer square root
        rbit = 32'h40000000 >> {cnt_r, 1'b0};
        rt = {1'b0, sq_res_r} + {1'b0, rbit};
        r_v = sq_v_r;
        if ({1'b0, sq_v_r} >= rt) begin
          r_v = sq_v_r - rt[31:0];
          r_res = (sq_res_r >> 1) + rbit;
        end else begin
          r_res = sq_res_r >> 1;
        end
        sq_v_nxt = r_v;
        sq_res_nxt = r_res;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST_ROOT) begin
          ryz_nxt = r_res[15:0];
          ld_vec = 1'b1;
          vx = tcch_pkg::dw_t'(az_r) <<< 20;
          vy = tcch_pkg::dw_t'(ay_r) <<< 20;
          vjob = JB_ROLL;
        end
      end

      ST_DONE: begin
        // hand the item to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_heading_nxt = head_r;
          out_yaw_nxt = yaw_r;
          out_cx_nxt = corr_r[0];
          out_cy_nxt = corr_r[1];
          out_cz_nxt = corr_r[2];
          out_stale_nxt = stale_r;
          out_hv_nxt = hv_r;
          out_cal_nxt = cal_r;
          out_act_nxt = track_r;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // start a vectoring pass
    if (ld_vec) begin
      zero_nxt = (vx == '0) && (vy == '0);
      flip_nxt = 1'b0;
      if (vx[tcch_pkg::DW-1]) begin
        cx_nxt = -vx;  cy_nxt = -vy;  cz_nxt = 32'h80000000;
      end else begin
        cx_nxt = vx;   cy_nxt = vy;   cz_nxt = '0;
      end
      cnt_nxt = '0;
      job_nxt = vjob;
      state_nxt = ST_VEC;
    end

    // start a rotation pass, folding the angle into the right half plane
    if (ld_rot) begin
      ra32 = {ra, 16'h0};
      zero_nxt = 1'b0;
      flip_nxt = ra32[31] ^ ra32[30];
      cz_nxt = (ra32[31] ^ ra32[30]) ? ra32 + 32'h80000000 : ra32;
      cx_nxt = tcch_pkg::dw_t'(tcch_pkg::GAIN_Q30);
      cy_nxt = '0;
      cnt_nxt = '0;
      job_nxt = rjob;
      state_nxt = ST_ROT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r <= JB_YAW;
      cnt_r <= '0;
      tilt_en_r <= 1'b1;
      decl_r <= '0;
      eps_r <= 16'd8;
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= '0;  max_r[i] <= '0;  off_r[i] <= '0;  prev_r[i] <= '0;
      end
      prev_time_r <= '0;
      stale_r <= '0;
      track_r <= 1'b0;
      have_r <= 1'b0;
      cal_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      job_r <= job_nxt;
      cnt_r <= cnt_nxt;
      tilt_en_r <= tilt_en_nxt;
      decl_r <= decl_nxt;
      eps_r <= eps_nxt;
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= min_nxt[i];  max_r[i] <= max_nxt[i];
        off_r[i] <= off_nxt[i];  prev_r[i] <= prev_nxt[i];
      end
      prev_time_r <= prev_time_nxt;
      stale_r <= stale_nxt;
      track_r <= track_nxt;
      have_r <= have_nxt;
      cal_r <= cal_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload
    for (int i = 0; i < 3; i++) corr_r[i] <= corr_nxt[i];
    ax_r <= ax_nxt;  ay_r <= ay_nxt;  az_r <= az_nxt;
    tilt_on_r <= tilt_on_nxt;  hv_r <= hv_nxt;
    yaw_r <= yaw_nxt;  head_r <= head_nxt;  roll_r <= roll_nxt;  pitch_r <= pitch_nxt;
    ryz_r <= ryz_nxt;
    cr_r <= cr_nxt;  sr_r <= sr_nxt;  cp_r <= cp_nxt;  sp_r <= sp_nxt;
    srsp_r <= srsp_nxt;  srcp_r <= srcp_nxt;
    cx_r <= cx_nxt;  cy_r <= cy_nxt;  cz_r <= cz_nxt;  acc_r <= acc_nxt;  xh_r <= xh_nxt;
    zero_r <= zero_nxt;  flip_r <= flip_nxt;  prod_r <= prod_nxt;
    sq_v_r <= sq_v_nxt;  sq_res_r <= sq_res_nxt;
    out_heading_r <= out_heading_nxt;  out_yaw_r <= out_yaw_nxt;
    out_cx_r <= out_cx_nxt;  out_cy_r <= out_cy_nxt;  out_cz_r <= out_cz_nxt;
    out_stale_r <= out_stale_nxt;
    out_hv_r <= out_hv_nxt;  out_cal_r <= out_cal_nxt;  out_act_r <= out_act_nxt;
  end

endmodule

// ----- rtl/tcch_checker.sv -----
// ----------------------------------------------------------------------------
// tcch_checker
// Port-level checks on the compass heading unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tilt_compensated_compass_heading_unit_defines.svh"

module tcch_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_wr_en,
  input logic [1:0]         cfg_index,
  input logic [15:0]        cfg_data,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_command,
  input logic signed [15:0] in_mag_x,
  input logic signed [15:0] in_mag_y,
  input logic signed [15:0] in_mag_z,
  input logic signed [15:0] in_accel_x,
  input logic signed [15:0] in_accel_y,
  input logic signed [15:0] in_accel_z,
  input logic               in_accel_valid,
  input logic [31:0]        in_time_ms,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        out_heading,
  input logic signed [15:0] out_yaw,
  input logic signed [16:0] out_corrected_x,
  input logic signed [16:0] out_corrected_y,
  input logic signed [16:0] out_corrected_z,
  input logic [31:0]        out_stale_time,
  input logic               out_heading_valid,
  input logic               out_calibration_done,
  input logic               out_calibration_active
);

  // hold a stalled result
  `TCCH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // busy in the cycle after an item is taken
  `TCCH_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready right after accepting an item")

  // command results carry no angles
  `TCCH_ASSERT_SAME(a_no_angle, out_valid && !out_heading_valid,
                    out_heading == 16'h0 && out_yaw == 16'sh0, "angle on a command result")

endmodule

bind tilt_compensated_compass_heading_unit tcch_checker u_tcch_checker (.*);

// ----- bench/tilt_compensated_compass_heading_unit_checker.sv -----
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_unit_checker
// Watches the config port and both channels of the compass heading unit,
// predicts every result item from its own copy of the calibration state and
// compares each one, field by field, against the oldest prediction in line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_compensated_compass_heading_unit_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          in_command,
  input  logic signed [15:0]  in_mag_x,
  input  logic signed [15:0]  in_mag_y,
  input  logic signed [15:0]  in_mag_z,
  input  logic signed [15:0]  in_accel_x,
  input  logic signed [15:0]  in_accel_y,
  input  logic signed [15:0]  in_accel_z,
  input  logic                in_accel_valid,
  input  logic [31:0]         in_time_ms,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [15:0]         out_heading,
  input  logic signed [15:0]  out_yaw,
  input  logic signed [16:0]  out_corrected_x,
  input  logic signed [16:0]  out_corrected_y,
  input  logic signed [16:0]  out_corrected_z,
  input  logic [31:0]         out_stale_time,
  input  logic                out_heading_valid,
  input  logic                out_calibration_done,
  input  logic                out_calibration_active,
  output int                  fail_count,
  output int                  pending_count
);

  typedef struct packed {
    logic [15:0]        heading;
    logic signed [15:0] yaw;
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic signed [16:0] cz;
    logic [31:0]        stale;
    logic               hvalid;
    logic               cal_done;
    logic               cal_active;
  } heading_result_t;

  localparam logic [31:0] ATAN_LUT [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

  localparam int STEPS = (tcch_pkg::CORDIC_ITERATIONS > 24) ? 24 :
                         tcch_pkg::CORDIC_ITERATIONS;

  // predictor copy of config and state
  logic              tilt_on;
  longint            decl;
  longint            epsilon;
  longint            axis_lo [3];
  longint            axis_hi [3];
  longint            offset [3];
  longint            last_corr [3];
  logic [31:0]       last_time;
  logic [31:0]       stale_acc;
  logic              tracking;
  logic              seen_sample;
  logic              calibrated;

  heading_result_t   expected_results [$];
  int                mismatches;

  assign fail_count    = mismatches;
  assign pending_count = expected_results.size();

  // atan2(y, x) as a 32-bit binary angle, vectoring CORDIC
  function automatic logic [31:0] cordic_atan2(input longint x, input longint y);
    logic [31:0] z;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_LUT[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_LUT[i];
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] round_angle(input logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h8000;
    return t[31:16];
  endfunction

  // cos and sin in Q30, rotation CORDIC with quadrant fold
  function automatic void cordic_sin_cos(input logic [15:0] a16, output longint c,
                                          output longint s);
    logic [31:0] a;
    logic        flip;
    longint      x;
    longint      y;
    longint      z;
    longint      xs;
    longint      ys;
    a = {a16, 16'h0};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    x = tcch_pkg::GAIN_Q30;
    y = 0;
    if (flip) a = a + 32'h80000000;
    z = longint'($signed(a));
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_LUT[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_LUT[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint floor_sqrt(input logic [31:0] v);
    logic [31:0] r;
    logic [31:0] b;
    r = 0;
    b = 32'h40000000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clamp17(input longint v);
    if (v > 65535) return 65535;
    if (v < -65536) return -65536;
    return v;
  endfunction

  // advance the predictor by one accepted item
  function automatic heading_result_t predict_heading(
      input tcch_pkg::cmd_t cmd, input longint mag [3], input longint acc [3],
      input logic acc_ok, input logic [31:0] now);
    heading_result_t r;
    longint corr [3];
    longint ryz, cr, sr, cp, sp, srsp, srcp, xh, yh, d;
    logic [15:0] roll, pitch, hdg;
    logic still;
    logic [32:0] sum;
    r = '0;
    corr = '{0, 0, 0};
    case (cmd)
      tcch_pkg::CMD_SAMPLE: begin
        if (tracking) begin
          for (int i = 0; i < 3; i++) begin
            if (!seen_sample || mag[i] < axis_lo[i]) axis_lo[i] = mag[i];
            if (!seen_sample || mag[i] > axis_hi[i]) axis_hi[i] = mag[i];
          end
          seen_sample = 1;
        end
        for (int i = 0; i < 3; i++) corr[i] = clamp17(mag[i] - offset[i]);
        r.yaw = round_angle(cordic_atan2(corr[0] * 1048576, corr[1] * 1048576));
        hdg = r.yaw;
        if (tilt_on && acc_ok) begin
          ryz = floor_sqrt(32'(acc[1] * acc[1] + acc[2] * acc[2]));
          roll = round_angle(cordic_atan2(acc[2] * 1048576, acc[1] * 1048576));
          pitch = round_angle(cordic_atan2(ryz * 1048576, -acc[0] * 1048576));
          cordic_sin_cos(roll, cr, sr);
          cordic_sin_cos(pitch, cp, sp);
          srsp = (sr * sp) >>> 30;
          srcp = (sr * cp) >>> 30;
          xh = corr[0] * cp + corr[2] * sp;
          yh = corr[0] * srsp + corr[1] * cr - corr[2] * srcp;
          hdg = round_angle(cordic_atan2(xh, yh));
        end
        r.heading = hdg + decl[15:0];
        r.hvalid = 1;
        still = 1;
        for (int i = 0; i < 3; i++) begin
          d = corr[i] - last_corr[i];
          if (d < 0) d = -d;
          if (!(d < epsilon)) still = 0;
        end
        if (!still) begin
          stale_acc = 0;
        end else if (last_time != 0) begin
          sum = {1'b0, stale_acc} + {1'b0, now - last_time};
          stale_acc = sum[32] ? 32'hFFFFFFFF : sum[31:0];
        end
        for (int i = 0; i < 3; i++) last_corr[i] = corr[i];
        last_time = now;
      end
      tcch_pkg::CMD_START: begin
        tracking = 1;
        seen_sample = 0;
        calibrated = 0;
      end
      tcch_pkg::CMD_FINISH: begin
        if (tracking) begin
          tracking = 0;
          if (!seen_sample) begin
            calibrated = 0;
          end else begin
            for (int i = 0; i < 3; i++) offset[i] = (axis_hi[i] + axis_lo[i]) >>> 1;
            calibrated = 1;
          end
        end
        for (int i = 0; i < 3; i++) corr[i] = offset[i];
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          offset[i] = mag[i];
          corr[i] = mag[i];
        end
        calibrated = 1;
      end
    endcase
    r.cx = corr[0][16:0];
    r.cy = corr[1][16:0];
    r.cz = corr[2][16:0];
    r.stale = stale_acc;
    r.cal_done = calibrated;
    r.cal_active = tracking;
    return r;
  endfunction

  // track config, predict on input handshakes, compare on output handshakes
  always @(posedge clk) begin
    longint mag [3];
    longint acc [3];
    heading_result_t got;
    heading_result_t want;
    if (!rst_n) begin
      tilt_on = 1;
      decl = 0;
      epsilon = 8;
      for (int i = 0; i < 3; i++) begin
        axis_lo[i] = 0;
        axis_hi[i] = 0;
        offset[i] = 0;
        last_corr[i] = 0;
      end
      last_time = 0;
      stale_acc = 0;
      tracking = 0;
      seen_sample = 0;
      calibrated = 0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          tcch_pkg::CFG_TILT_ENABLE:   tilt_on = cfg_data[0];
          tcch_pkg::CFG_DECLINATION:   decl = longint'($signed(cfg_data));
          tcch_pkg::CFG_STALE_EPSILON: epsilon = longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        mag = '{in_mag_x, in_mag_y, in_mag_z};
        acc = '{in_accel_x, in_accel_y, in_accel_z};
        expected_results.push_back(predict_heading(tcch_pkg::cmd_t'(in_command), mag, acc,
                                                   in_accel_valid, in_time_ms));
      end
      if (out_valid && out_ready) begin
        got = '{out_heading, out_yaw, out_corrected_x, out_corrected_y,
                out_corrected_z, out_stale_time, out_heading_valid,
                out_calibration_done, out_calibration_active};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result item with nothing expected", $time);
        end else begin
          want = expected_results.pop_front();
          if (got.heading !== want.heading || got.yaw !== want.yaw ||
              got.cx !== want.cx || got.cy !== want.cy || got.cz !== want.cz ||
              got.stale !== want.stale || got.hvalid !== want.hvalid ||
              got.cal_done !== want.cal_done || got.cal_active !== want.cal_active) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected hdg=%0d yaw=%0d c=%0d,%0d,%0d stale=%0d v=%b d=%b a=%b",
                       $time, want.heading, want.yaw, want.cx, want.cy, want.cz,
                       want.stale, want.hvalid, want.cal_done, want.cal_active);
              $display("%0t: actual   hdg=%0d yaw=%0d c=%0d,%0d,%0d stale=%0d v=%b d=%b a=%b",
                       $time, got.heading, got.yaw, got.cx, got.cy, got.cz,
                       got.stale, got.hvalid, got.cal_done, got.cal_active);
            end
          end
        end
      end
    end
  end

endmodule

// ----- bench/tilt_compensated_compass_heading_unit_tb.sv -----
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_unit_tb
// Drives directed and random compass commands through the heading unit in
// several register settings, with bursty input and stalling output; the
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_compensated_compass_heading_unit_tb;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_command;
  logic signed [15:0] in_mag_x, in_mag_y, in_mag_z;
  logic signed [15:0] in_accel_x, in_accel_y, in_accel_z;
  logic               in_accel_valid;
  logic [31:0]        in_time_ms;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        out_heading;
  logic signed [15:0] out_yaw;
  logic signed [16:0] out_corrected_x, out_corrected_y, out_corrected_z;
  logic [31:0]        out_stale_time;
  logic               out_heading_valid, out_calibration_done, out_calibration_active;
  int                 fail_count;
  int                 pending_count;

  int                 burst_left;
  logic [31:0]        clock_ms;
  logic signed [15:0] base_x, base_y, base_z;

  tilt_compensated_compass_heading_unit dut (.*);

  tilt_compensated_compass_heading_unit_checker checker_i (.*);

  // 100 MHz clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // stall the result side: free-running, random, and long-stall stretches
  initial begin
    int mode;
    int span;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 400);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = $urandom_range(0, 1);
          default: out_ready = ($urandom_range(0, 29) == 0);
        endcase
      end
    end
  end

  // run limit
  initial begin
    #50ms;
    $display("tilt_compensated_compass_heading_unit: mismatch");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // present one item and hold it until accepted; gaps come between bursts
  task automatic send_item(input tcch_pkg::cmd_t cmd, input logic signed [15:0] mx,
                           input logic signed [15:0] my, input logic signed [15:0] mz,
                           input logic signed [15:0] ax, input logic signed [15:0] ay,
                           input logic signed [15:0] az, input logic av,
                           input logic [31:0] t);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid       = 1'b1;
    in_command     = cmd;
    in_mag_x       = mx;
    in_mag_y       = my;
    in_mag_z       = mz;
    in_accel_x     = ax;
    in_accel_y     = ay;
    in_accel_z     = az;
    in_accel_valid = av;
    in_time_ms     = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left == 0) in_valid = 1'b0;
  endtask

  task automatic sample(input logic signed [15:0] mx, input logic signed [15:0] my,
                        input logic signed [15:0] mz);
    clock_ms = clock_ms + $urandom_range(1, 50);
    send_item(tcch_pkg::CMD_SAMPLE, mx, my, mz, $urandom, $urandom, $urandom,
              $urandom_range(0, 3) != 0, clock_ms);
  endtask

  // hold until every predicted result has been seen
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  function automatic logic signed [15:0] near(input logic signed [15:0] b, input int span);
    return b + 16'($urandom_range(0, 2 * span) - span);
  endfunction

  // one random phase: mostly calibration runs and drifting samples
  task automatic random_phase(input int count);
    int sent;
    int kind;
    int n;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        // calibration run
        send_item(tcch_pkg::CMD_START, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
        n = $urandom_range(0, 6);
        repeat (n) sample($urandom, $urandom, $urandom);
        send_item(($urandom_range(0, 4) == 0) ? tcch_pkg::CMD_START : tcch_pkg::CMD_FINISH,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        sent += n + 2;
      end else if (kind < 7) begin
        // slowly drifting run, exercises the stale timer
        base_x = $urandom;
        base_y = $urandom;
        base_z = $urandom;
        n = $urandom_range(2, 10);
        repeat (n) begin
          base_x = near(base_x, 6);
          base_y = near(base_y, 6);
          base_z = near(base_z, 6);
          if ($urandom_range(0, 15) == 0) clock_ms = $urandom_range(0, 1) ? 0 : $urandom;
          sample(base_x, base_y, base_z);
        end
        sent += n;
      end else if (kind == 7) begin
        send_item(tcch_pkg::CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
        sent++;
      end else begin
        // arbitrary noise item
        send_item(tcch_pkg::cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = tcch_pkg::CFG_TILT_ENABLE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_command = tcch_pkg::CMD_SAMPLE;
    in_mag_x = '0;
    in_mag_y = '0;
    in_mag_z = '0;
    in_accel_x = '0;
    in_accel_y = '0;
    in_accel_z = '0;
    in_accel_valid = 1'b0;
    in_time_ms = '0;
    burst_left = 0;
    clock_ms = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: zero vector, extremes, stale timing, each command path
    send_item(tcch_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 1'b1, 0);
    send_item(tcch_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 1'b1, 100);
    send_item(tcch_pkg::CMD_SAMPLE, 3, -2, 1, 0, 0, 16384, 1'b1, 150);
    send_item(tcch_pkg::CMD_SAMPLE, 4, -1, 2, 0, 0, 16384, 1'b1, 32'h0000_0010);
    send_item(tcch_pkg::CMD_SAMPLE, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1,
              32'hFFFF_FFFF);
    send_item(tcch_pkg::CMD_SAMPLE, -32768, -32768, -32768, -32768, -32768, -32768, 1'b1, 5);
    send_item(tcch_pkg::CMD_SAMPLE, -32768, 0, 100, -32768, 0, 0, 1'b0, 6);
    send_item(tcch_pkg::CMD_FINISH, 1, 2, 3, 0, 0, 0, 1'b0, 7);
    send_item(tcch_pkg::CMD_START, 0, 0, 0, 0, 0, 0, 1'b0, 8);
    send_item(tcch_pkg::CMD_FINISH, 0, 0, 0, 0, 0, 0, 1'b0, 9);
    send_item(tcch_pkg::CMD_START, 0, 0, 0, 0, 0, 0, 1'b0, 10);
    send_item(tcch_pkg::CMD_SAMPLE, 1000, -3001, 77, 100, -200, 16000, 1'b1, 11);
    send_item(tcch_pkg::CMD_SAMPLE, -1500, 2000, -78, 5000, 300, -16000, 1'b1, 12);
    send_item(tcch_pkg::CMD_SAMPLE, 32767, -32768, 0, 0, 16384, 0, 1'b1, 13);
    send_item(tcch_pkg::CMD_FINISH, 0, 0, 0, 0, 0, 0, 1'b0, 14);
    send_item(tcch_pkg::CMD_LOAD, -32768, 32767, -32768, 0, 0, 0, 1'b0, 15);
    send_item(tcch_pkg::CMD_SAMPLE, 32767, -32768, 32767, 0, -16384, 0, 1'b1, 16);
    send_item(tcch_pkg::CMD_SAMPLE, -32768, 32767, -32768, 1, 1, 1, 1'b1, 17);
    send_item(tcch_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, 1'b0, 18);
    send_item(tcch_pkg::CMD_SAMPLE, 0, 5, 0, 0, 0, 0, 1'b1, 20);
    send_item(tcch_pkg::CMD_SAMPLE, -7, 0, 0, 0, 0, 0, 1'b1, 20);
    drain();

    // register settings, extremes first, then random ones
    write_reg(tcch_pkg::CFG_TILT_ENABLE, 16'd0);
    write_reg(tcch_pkg::CFG_DECLINATION, 16'h7FFF);
    write_reg(tcch_pkg::CFG_STALE_EPSILON, 16'd0);
    random_phase(300);
    drain();
    write_reg(tcch_pkg::CFG_TILT_ENABLE, 16'd1);
    write_reg(tcch_pkg::CFG_DECLINATION, 16'h8000);
    write_reg(tcch_pkg::CFG_STALE_EPSILON, 16'hFFFF);
    random_phase(300);
    drain();
    repeat (5) begin
      write_reg(tcch_pkg::CFG_TILT_ENABLE, $urandom_range(0, 3) != 0);
      write_reg(tcch_pkg::CFG_DECLINATION, $urandom);
      write_reg(tcch_pkg::CFG_STALE_EPSILON,
                $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom);
      random_phase(270);
      drain();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("tilt_compensated_compass_heading_unit: match");
    end else begin
      $display("tilt_compensated_compass_heading_unit: mismatch");
    end
    $finish;
  end

endmodule
